### hw/rtl/mffu_pkg.sv
// Package for the motor feedback frame unwrap block.
// Holds the frame layout and the angle result types; no dependencies.
package mffu_pkg;

    localparam int AngleWidth = 33;

    typedef logic [AngleWidth-1:0] angle_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [3:0]  unused;
        logic [15:0] encoder;
        logic [11:0] velocity;
        logic [11:0] torque;
        logic [7:0]  driver_temp;
        logic [7:0]  winding_temp;
    } frame_t;

    typedef struct packed {
        angle_t total;
        angle_t change;
    } angle_pair_t;

endpackage

### hw/rtl/mffu_unwrap.sv
// Multi-turn unwrap: offset capture, saturating turn counter and angle delta.
// Depends on mffu_pkg.
module mffu_unwrap
    import mffu_pkg::*;
#(
    parameter int ENCODER_SPAN = 65536,
    parameter int TURN_BITS    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        take,
    input  logic [15:0] encoder,
    output angle_pair_t angles
);

    localparam logic signed [16:0] HALF_POS  = 17'(ENCODER_SPAN / 2);
    localparam logic signed [16:0] HALF_NEG  = -HALF_POS;
    localparam angle_t             SPAN_STEP = AngleWidth'(ENCODER_SPAN);
    localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
    localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

    logic                        offset_taken_reg;
    logic [15:0]                 prev_pos_reg;
    logic [15:0]                 offset_reg;
    logic signed [TURN_BITS-1:0] turn_reg;
    logic signed [TURN_BITS-1:0] turn_next;
    angle_t                      base_reg;
    angle_t                      base_next;
    angle_t                      prev_angle_reg;
    logic signed [16:0]          diff;
    logic [15:0]                 offset_eff;
    angle_t                      total;

    always_comb begin
        diff      = $signed({1'b0, encoder}) - $signed({1'b0, prev_pos_reg});
        turn_next = turn_reg;
        base_next = base_reg;
        if (offset_taken_reg) begin
            if (diff > HALF_POS) begin
                if (turn_reg != TURN_MIN) begin
                    turn_next = turn_reg - 1'b1;
                    base_next = base_reg - SPAN_STEP;
                end
            end else if (diff < HALF_NEG) begin
                if (turn_reg != TURN_MAX) begin
                    turn_next = turn_reg + 1'b1;
                    base_next = base_reg + SPAN_STEP;
                end
            end
        end
        offset_eff    = offset_taken_reg ? offset_reg : encoder;
        total         = base_next + AngleWidth'(encoder) - AngleWidth'(offset_eff);
        angles.total  = total;
        angles.change = total - prev_angle_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_taken_reg <= 1'b0;
            prev_pos_reg     <= '0;
            offset_reg       <= '0;
            turn_reg         <= '0;
            base_reg         <= '0;
            prev_angle_reg   <= '0;
        end else if (take) begin
            offset_taken_reg <= 1'b1;
            prev_pos_reg     <= encoder;
            offset_reg       <= offset_eff;
            turn_reg         <= turn_next;
            base_reg         <= base_next;
            prev_angle_reg   <= total;
        end
    end

endmodule

### hw/rtl/motor_feedback_frame_unwrap.sv
// Top level of the motor feedback frame unwrap block: input and result registers.
// Depends on mffu_pkg and mffu_unwrap.
//
// Takes one 8-byte feedback frame per request and returns one result per frame:
// the unpacked status, encoder, velocity, torque and temperature fields, plus the
// multi-turn angle relative to the first frame's encoder and its change since
// the previous frame. A frame is accepted every cycle while results are taken.
// Results are registered: each frame is held in the input register, and the single
// unwrap pass reads it and writes the result register when that frame advances. A
// result held by a low m_ready holds a pending frame in the input register and
// drops s_ready. The first frame after reset sets the zero offset. The turn
// counter saturates at its signed limits, and the angles are 33-bit two's
// complement, wrapping if the parameters make them wider.
module motor_feedback_frame_unwrap
    import mffu_pkg::*;
#(
    parameter int ENCODER_SPAN = 65536,
    parameter int TURN_BITS    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_frame_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_motor_status,
    output logic [15:0] m_encoder_position,
    output logic [11:0] m_velocity_raw,
    output logic [11:0] m_torque_raw,
    output logic [7:0]  m_driver_temperature,
    output logic [7:0]  m_winding_temperature,
    output logic [32:0] m_total_angle,
    output logic [32:0] m_angle_change
);

    logic        in_valid_reg;
    frame_t      in_frame_reg;
    logic        out_valid_reg;
    frame_t      out_frame_reg;
    angle_pair_t out_angles_reg;
    angle_pair_t angles;
    logic        advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    mffu_unwrap #(
        .ENCODER_SPAN (ENCODER_SPAN),
        .TURN_BITS    (TURN_BITS)
    ) u_unwrap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (advance),
        .encoder (in_frame_reg.encoder),
        .angles  (angles)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_frame_reg <= frame_t'(s_frame_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_frame_reg  <= in_frame_reg;
            out_angles_reg <= angles;
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_motor_status        = out_frame_reg.status;
    assign m_encoder_position    = out_frame_reg.encoder;
    assign m_velocity_raw        = out_frame_reg.velocity;
    assign m_torque_raw          = out_frame_reg.torque;
    assign m_driver_temperature  = out_frame_reg.driver_temp;
    assign m_winding_temperature = out_frame_reg.winding_temp;
    assign m_total_angle         = out_angles_reg.total;
    assign m_angle_change        = out_angles_reg.change;

`ifndef SYNTHESIS
    a_advance_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result register not loaded after advance");

    a_drained_output_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && m_ready && !advance |=> !out_valid_reg)
        else $error("result delivered twice");

    a_blocked_input_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_frame_reg))
        else $error("pending request lost in input register");

    a_change_matches_total: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && $past(advance) |=>
            out_angles_reg.change == out_angles_reg.total - $past(out_angles_reg.total))
        else $error("angle change inconsistent with consecutive totals");
`endif

endmodule
